// ----- rtl/slot_pool_free_list_allocator_unit_assert.svh -----
// Assertion macros used by the allocator controller.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef SLOT_POOL_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define SLOT_POOL_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPFLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spfla_pkg.sv -----
package spfla_pkg;

  // Pool size; slot numbers are 10 bits, so the usable pool is capped at 1024.
  localparam int POOL_SLOTS = 1024;
  localparam int SLOT_W     = 10;
  localparam int SLOT_SPACE = 1 << SLOT_W;
  localparam int SLOT_LIMIT = (POOL_SLOTS < SLOT_SPACE) ? POOL_SLOTS : SLOT_SPACE;
  localparam int MARK_W     = SLOT_W + 1;
  localparam int LINK_W     = SLOT_W + 1;
  localparam int STATUS_W   = 2;
  localparam int REQ_W      = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;  // a request beat is accepted this cycle
    logic pop;   // finish a free-list pop with the link read data
  } spfla_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pop_needed;  // the waiting request is an allocate from the free list
  } spfla_stat_t;

endpackage

// ----- rtl/spfla_req_if.sv -----
interface spfla_req_if;
  logic                          valid;
  logic                          ready;
  logic [spfla_pkg::REQ_W-1:0]   req_type;
  logic [spfla_pkg::SLOT_W-1:0]  slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

// ----- rtl/spfla_rsp_if.sv -----
interface spfla_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [spfla_pkg::SLOT_W-1:0]    granted_slot;
  logic [spfla_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output granted_slot, output status, input ready);
  modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

// ----- rtl/spfla_ram.sv -----
module spfla_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spfla_datapath.sv -----
module spfla_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  spfla_pkg::spfla_cmd_t           cmd,
  output spfla_pkg::spfla_stat_t          stat,
  input  logic [spfla_pkg::REQ_W-1:0]     req_type,
  input  logic [spfla_pkg::SLOT_W-1:0]    slot_index,
  output logic [spfla_pkg::SLOT_W-1:0]    granted_slot,
  output logic [spfla_pkg::STATUS_W-1:0]  status
);

  logic [spfla_pkg::SLOT_W-1:0] free_head;
  logic                         free_nonempty;
  logic [spfla_pkg::MARK_W-1:0] fill_mark;

  logic                         link_we;
  logic [spfla_pkg::LINK_W-1:0] link_wdata;
  logic [spfla_pkg::LINK_W-1:0] link_rdata;

  logic                           slot_ok;
  logic                           mark_ok;
  logic [spfla_pkg::SLOT_W-1:0]   granted_next;
  logic [spfla_pkg::STATUS_W-1:0] status_next;

  assign slot_ok = {1'b0, slot_index} < spfla_pkg::MARK_W'(spfla_pkg::SLOT_LIMIT);
  assign mark_ok = fill_mark < spfla_pkg::MARK_W'(spfla_pkg::SLOT_LIMIT);

  assign stat.pop_needed = (req_type == spfla_pkg::REQ_ALLOC) && free_nonempty;

  // A push links the new head to the old one; bit SLOT_W says a next entry exists.
  assign link_we    = cmd.take && (req_type == spfla_pkg::REQ_FREE) && slot_ok;
  assign link_wdata = {free_nonempty, free_head};

  // The link of the current head is read every cycle; a pop uses the registered read data in the next cycle.
  spfla_ram #(
    .WIDTH (spfla_pkg::LINK_W),
    .DEPTH (spfla_pkg::SLOT_SPACE)
  ) u_link_store (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot_index),
    .wdata (link_wdata),
    .raddr (free_head),
    .rdata (link_rdata)
  );

  always_comb begin
    granted_next = '0;
    status_next  = spfla_pkg::ST_OK;
    case (req_type)
      spfla_pkg::REQ_ALLOC: begin
        if (mark_ok) begin
          granted_next = fill_mark[spfla_pkg::SLOT_W-1:0];
        end else begin
          status_next = spfla_pkg::ST_FULL;
        end
      end
      spfla_pkg::REQ_FREE: begin
        if (!slot_ok) begin
          status_next = spfla_pkg::ST_RANGE;
        end
      end
      default: begin
        status_next = spfla_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head     <= '0;
      free_nonempty <= 1'b0;
      fill_mark     <= '0;
    end else if (cmd.pop) begin
      free_head     <= link_rdata[spfla_pkg::SLOT_W-1:0];
      free_nonempty <= link_rdata[spfla_pkg::SLOT_W];
    end else if (cmd.take) begin
      case (req_type)
        spfla_pkg::REQ_ALLOC: begin
          if (!free_nonempty && mark_ok) begin
            fill_mark <= fill_mark + spfla_pkg::MARK_W'(1);
          end
        end
        spfla_pkg::REQ_FREE: begin
          if (slot_ok) begin
            free_head     <= slot_index;
            free_nonempty <= 1'b1;
          end
        end
        spfla_pkg::REQ_RESET: begin
          free_head     <= '0;
          free_nonempty <= 1'b0;
          fill_mark     <= '0;
        end
        default: begin
          free_head <= free_head;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      granted_slot <= free_head;
      status       <= spfla_pkg::ST_OK;
    end else if (cmd.take && !stat.pop_needed) begin
      granted_slot <= granted_next;
      status       <= status_next;
    end
  end

endmodule

// ----- rtl/spfla_ctrl.sv -----
`include "slot_pool_free_list_allocator_unit_assert.svh"

module spfla_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  spfla_pkg::spfla_stat_t stat,
  output spfla_pkg::spfla_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state;
  logic   out_valid;

  // A new beat is taken only when the result register is free by the next edge.
  assign req_ready = (state == S_IDLE) && (!out_valid || rsp_ready);
  assign cmd.take  = req_valid && req_ready;
  assign cmd.pop   = (state == S_POP);
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.take) begin
            if (stat.pop_needed) begin
              state     <= S_POP;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (rsp_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_POP: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  `SPFLA_ASSERT_SAME(a_no_take_in_pop, state == S_POP, !req_ready && !out_valid,
                     "request taken or result shown while a pop is in flight")
  `SPFLA_ASSERT_NEXT(a_pop_follows, cmd.take && stat.pop_needed,
                     state == S_POP && !out_valid, "free-list pop did not start")
  `SPFLA_ASSERT_NEXT(a_direct_result, cmd.take && !stat.pop_needed,
                     out_valid && state == S_IDLE, "direct result not presented")
  `SPFLA_ASSERT_NEXT(a_result_held, out_valid && !rsp_ready, out_valid,
                     "stalled result was dropped")

endmodule

// ----- rtl/slot_pool_free_list_allocator_unit.sv -----
// Fixed-size slot allocator with a last-in first-out free list.
// The req channel carries one request per beat: allocate, free a slot, or reset the
// pool (req_type), with slot_index naming the slot to free. The rsp channel returns
// exactly one beat per request, in order: granted_slot for an allocate, and status
// (ok, pool full, or free index out of range).
// An allocate served from the free list reads the head's link from the link store,
// a synchronous single-read memory, so it passes through the S_POP state before its
// result beat. Every other request gives its result in the cycle after acceptance.
// Sustained rate while the sink is ready: one request per cycle for frees, resets and
// fill-mark allocates; a free-list pop holds off the next request while in S_POP.
// The result sits in an output register; the next request is accepted in the same
// cycle that the waiting result is taken, so a ready sink sees no bubble.
// When the sink stalls, the held result stays valid and unchanged and no new request
// is accepted until it is taken.
// Reset (rst, synchronous) empties the free list, zeroes the fill mark and drops any
// pending result. The link store keeps its contents; a pop only uses written entries.
module slot_pool_free_list_allocator_unit (
  input logic        clk,
  input logic        rst,
  spfla_req_if.sink  req,
  spfla_rsp_if.source rsp
);

  spfla_pkg::spfla_cmd_t  cmd;
  spfla_pkg::spfla_stat_t stat;

  // The controller sequences acceptance, the free-list pop state and the result valid.
  spfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the free-list head, the fill mark, the link store and the
  // result register.
  spfla_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .slot_index   (req.slot_index),
    .granted_slot (rsp.granted_slot),
    .status       (rsp.status)
  );

endmodule

// ----- tb/grant_checker.sv -----
// Watches both channels of the allocator, keeps its own copy of the pool
// state and checks every result beat against the oldest expected grant.
module grant_checker
  import spfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spfla_req_if req,
  spfla_rsp_if rsp,
  output int   mismatches,
  output int   awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } grant_t;

  // Shadow pool: list head, list-occupied flag, high-water mark and links.
  logic [SLOT_W-1:0] head_slot;
  logic              list_live;
  logic [MARK_W-1:0] next_fresh;
  logic [LINK_W-1:0] links [SLOT_SPACE];
  grant_t            grants_due [$];

  initial mismatches = 0;

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies one request to the shadow pool and returns the grant it must produce.
  function automatic grant_t serve(input logic [REQ_W-1:0] kind,
                                   input logic [SLOT_W-1:0] slot);
    grant_t            res;
    logic [LINK_W-1:0] entry;
    res = '0;
    res.status = ST_OK;
    case (kind)
      REQ_ALLOC: begin
        if (list_live) begin
          entry = links[head_slot];
          res.slot = head_slot;
          head_slot = entry[SLOT_W-1:0];
          list_live = entry[SLOT_W];
        end else if (next_fresh < SLOT_LIMIT) begin
          res.slot = next_fresh[SLOT_W-1:0];
          next_fresh = next_fresh + 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_FREE: begin
        if (int'(slot) < SLOT_LIMIT) begin
          links[slot] = {list_live, head_slot};
          head_slot = slot;
          list_live = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      REQ_RESET: begin
        head_slot = '0;
        list_live = 1'b0;
        next_fresh = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      head_slot = '0;
      list_live = 1'b0;
      next_fresh = '0;
      grants_due.delete();
    end else begin
      // A result always belongs to an earlier request, so retire before predicting.
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          note_mismatch($sformatf("result slot %0d status %0d with nothing expected",
                                  rsp.granted_slot, rsp.status));
        end else begin
          want = grants_due.pop_front();
          if (rsp.granted_slot !== want.slot)
            note_mismatch($sformatf("granted_slot %0d, expected %0d",
                                    rsp.granted_slot, want.slot));
          if (rsp.status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        end
      end
      if (req.valid && req.ready)
        grants_due.push_back(serve(req.req_type, req.slot_index));
    end
    awaiting <= grants_due.size();
  end

endmodule

// ----- tb/tb_slot_pool_free_list_allocator_unit.sv -----
// Testbench top for the slot pool allocator. It makes the stimulus, shapes the
// handshake timing on both channels and gives the verdict; all prediction and
// comparison is done by the grant checker that sits beside the block.
module tb_slot_pool_free_list_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code 3 is not used by the block; it must still answer with ok.
  localparam logic [spfla_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 14;
  localparam int RX_HOLD      = 80;
  localparam int TOTAL_BEATS  = 1500;
  localparam int SWEEP_AT     = 320;
  localparam int PAUSE_AT     = 150;
  localparam int HOLD_AT      = 100;
  localparam int CALM_FROM    = 180;
  localparam int CALM_TO      = 280;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;

  logic clk;
  logic rst;

  spfla_req_if req_ch ();
  spfla_rsp_if rsp_ch ();

  int mismatches;
  int awaiting;

  // Flags shared between the sender and the receiver processes, and the sender's beat count.
  bit calm;
  bit hold_rx;
  int beats_sent;

  slot_pool_free_list_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  grant_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a run in which no beat moves on either channel for a long time is hung.
  int stuck_cycles;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_slot_pool_free_list_allocator_unit: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver. Ready drops now and then, never inside the calm window, and once
  // it stays low for a long stretch so that the output register fills up and
  // the block has to stall its request channel.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < RX_HOLD; n++) @(posedge clk);
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offers one request beat and returns at the edge where it is accepted.
  // Random gaps are inserted first; valid stays high between back-to-back beats.
  task automatic offer(input logic [spfla_pkg::REQ_W-1:0] kind,
                       input logic [spfla_pkg::SLOT_W-1:0] slot);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.slot_index <= slot;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  // The checker updates its count with a nonblocking write, so the value seen
  // after an edge always includes every beat accepted before that edge.
  task automatic wait_drained();
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Free slots are mostly drawn from the low numbers that allocation hands out,
  // so that frees hit live slots and build long chains; the rest span all values.
  function automatic logic [spfla_pkg::SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 9) < 8) return spfla_pkg::SLOT_W'($urandom_range(0, 47));
    return spfla_pkg::SLOT_W'($urandom);
  endfunction

  initial begin
    int  len;
    int  bias;
    int  mode;
    bit  swept;
    bit  paused;
    bit  held;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= spfla_pkg::REQ_ALLOC;
    req_ch.slot_index <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: fresh grants from the fill mark, recycling of slot 0
    // and of the top slot, double free, the unused code, and pool resets.
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(spfla_pkg::REQ_ALLOC, '1);
    offer(spfla_pkg::REQ_FREE, '0);
    offer(spfla_pkg::REQ_FREE, '1);
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(REQ_UNUSED, '1);
    offer(REQ_UNUSED, '0);
    offer(spfla_pkg::REQ_FREE, '0);
    offer(spfla_pkg::REQ_FREE, '0);
    offer(spfla_pkg::REQ_ALLOC, '1);
    offer(spfla_pkg::REQ_ALLOC, '1);
    offer(spfla_pkg::REQ_ALLOC, '1);
    offer(spfla_pkg::REQ_FREE, 10'd1);
    offer(spfla_pkg::REQ_FREE, 10'd2);
    offer(spfla_pkg::REQ_RESET, '1);
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(spfla_pkg::REQ_FREE, 10'd512);
    offer(spfla_pkg::REQ_ALLOC, '0);
    offer(spfla_pkg::REQ_RESET, '0);
    offer(spfla_pkg::REQ_ALLOC, '0);

    // Random part: mostly bursts of allocates and frees with a random lean,
    // so that the free list grows deep and then drains, with resets and the
    // unused code sprinkled in as noise.
    while (beats_sent < TOTAL_BEATS) begin
      if (!paused && beats_sent >= PAUSE_AT) begin
        // The sender stops until every result has come back.
        paused = 1'b1;
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      if (!held && beats_sent >= HOLD_AT) begin
        held = 1'b1;
        hold_rx = 1'b1;
      end
      calm = (beats_sent >= CALM_FROM) && (beats_sent < CALM_TO);

      if (!swept && beats_sent >= SWEEP_AT) begin
        // Fill the whole pool from an empty state and run past it into the
        // pool-full case, then recycle two slots and exhaust the pool again.
        swept = 1'b1;
        offer(spfla_pkg::REQ_RESET, pick_slot());
        repeat (spfla_pkg::SLOT_LIMIT + 4)
          offer(spfla_pkg::REQ_ALLOC, spfla_pkg::SLOT_W'($urandom));
        offer(spfla_pkg::REQ_FREE, '1);
        offer(spfla_pkg::REQ_FREE, '0);
        repeat (3) offer(spfla_pkg::REQ_ALLOC, spfla_pkg::SLOT_W'($urandom));
        offer(spfla_pkg::REQ_RESET, spfla_pkg::SLOT_W'($urandom));
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 4) begin
          offer(spfla_pkg::REQ_RESET, spfla_pkg::SLOT_W'($urandom));
        end else if (mode < 8) begin
          offer(REQ_UNUSED, spfla_pkg::SLOT_W'($urandom));
        end else begin
          len  = $urandom_range(1, 16);
          bias = $urandom_range(20, 80);
          repeat (len) begin
            if ($urandom_range(0, 99) < bias)
              offer(spfla_pkg::REQ_ALLOC, spfla_pkg::SLOT_W'($urandom));
            else
              offer(spfla_pkg::REQ_FREE, pick_slot());
          end
        end
      end
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // Let every outstanding result arrive, then keep watching the response channel
    // so that a stray extra beat would still be caught.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_slot_pool_free_list_allocator_unit: done, clean");
    end else begin
      $display("tb_slot_pool_free_list_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spfla_pkg.sv
rtl/spfla_req_if.sv
rtl/spfla_rsp_if.sv
rtl/spfla_ram.sv
rtl/spfla_datapath.sv
rtl/spfla_ctrl.sv
rtl/slot_pool_free_list_allocator_unit.sv
tb/grant_checker.sv
tb/tb_slot_pool_free_list_allocator_unit.sv
